### src/plist_pkg.sv
// Shared constants, codes and types for the positional ordered list.
`timescale 1ns / 1ps
package plist_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned POS_W  = 8;
  localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 5;

  typedef logic [DATA_W-1:0] data_t;

  localparam logic [CMD_W-1:0] CMD_INSERT_AT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE_AT    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE_NEG   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_APPEND       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PUSH         = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DELETE_FIRST = 3'd5;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_LOAD
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctl_t;

endpackage

### src/plist_cell.sv
// One list slot: holds, loads, or takes the entry of a neighbor.
`timescale 1ns / 1ps
module plist_cell (
  input  logic               clk_i,
  input  plist_pkg::cell_ctl_t ctl_i,
  input  plist_pkg::data_t   left_i,
  input  plist_pkg::data_t   right_i,
  input  plist_pkg::data_t   load_i,
  output plist_pkg::data_t   entry_o
);
  import plist_pkg::*;

  data_t entry_q;
  data_t entry_d;

  always_comb begin
    case (ctl_i.op)
      CELL_FROM_LEFT:  entry_d = left_i;
      CELL_FROM_RIGHT: entry_d = right_i;
      CELL_LOAD:       entry_d = load_i;
      default:         entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### src/positional_ordered_list.sv
// Top level of the positional ordered list: control and the row of cells.
//
// Keeps an ordered list of up to DEPTH signed 32-bit entries, head at
// position 0. Commands: insert at, delete at, delete first negative,
// append, push, delete first.
// Command channel: a command transfer happens at a rising edge with start
// high and busy low. busy is never raised, so one command is taken each
// cycle.
// Result channel: done_o is high for one cycle, the cycle after the
// command transfer, with status_o, removed_value_o and length_o.
// Throughput is one command per cycle; the row of cells shifts in
// parallel and the first negative entry is found by a priority mask,
// all within the cycle of the transfer.
// The receiver cannot stall; every result must be taken when shown.
// Reset clears the length to zero and drops any pending result; entry
// contents are not cleared and are only read below the current length.
`timescale 1ns / 1ps
module positional_ordered_list (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [plist_pkg::CMD_W-1:0]  command_i,
  input  logic [plist_pkg::POS_W-1:0]  position_i,
  input  logic signed [plist_pkg::DATA_W-1:0] value_i,
  output logic                         done_o,
  output logic [plist_pkg::STAT_W-1:0] status_o,
  output logic signed [plist_pkg::DATA_W-1:0] removed_value_o,
  output logic [plist_pkg::LEN_W-1:0]  length_o
);
  import plist_pkg::*;

  logic             acc;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CMP_W-1:0] cnt_ext, pos_ext, tgt;
  logic             full, ins_go, del_go, use_neg;
  logic [STAT_W-1:0] status_q, status_d;
  data_t            removed_q, removed_d;
  logic             done_q;

  data_t            entry [DEPTH];
  data_t            rem   [DEPTH];
  logic [DEPTH-1:0] neg;
  cell_ctl_t        ctl   [DEPTH];

  assign busy    = 1'b0;
  assign acc     = start & ~busy;
  assign cnt_ext = CMP_W'(count_q);
  assign pos_ext = CMP_W'(position_i);
  assign full    = (count_q == CNT_W'(DEPTH));

  always_comb begin
    ins_go   = 1'b0;
    del_go   = 1'b0;
    use_neg  = 1'b0;
    tgt      = '0;
    status_d = ST_IGNORED;
    case (command_i)
      CMD_INSERT_AT: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (pos_ext <= cnt_ext) begin
          ins_go = 1'b1;
          tgt    = pos_ext;
        end
      end
      CMD_APPEND: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ins_go = 1'b1;
          tgt    = cnt_ext;
        end
      end
      CMD_PUSH: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ins_go = 1'b1;
        end
      end
      CMD_DELETE_AT: begin
        if (pos_ext < cnt_ext) begin
          del_go = 1'b1;
          tgt    = pos_ext;
        end
      end
      CMD_DELETE_NEG: begin
        if (|neg) begin
          del_go  = 1'b1;
          use_neg = 1'b1;
        end
      end
      CMD_DELETE_FIRST: begin
        if (count_q != '0) begin
          del_go = 1'b1;
        end
      end
      default: ;
    endcase
    if (ins_go || del_go) begin
      status_d = ST_DONE;
    end
    ins_go = ins_go & acc;
    del_go = del_go & acc;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX  = CMP_W'(i);
    localparam logic [DEPTH-1:0] UPTO = {DEPTH{1'b1}} >> (DEPTH - 1 - i);

    logic  neg_ge, neg_hit, ge, hit;
    data_t left, right;

    assign neg[i]  = entry[i][DATA_W-1] & (IDX < cnt_ext);
    assign neg_ge  = |(neg & UPTO);
    assign neg_hit = neg[i] & ~|(neg & (UPTO >> 1));
    assign ge      = use_neg ? neg_ge  : (IDX >= tgt);
    assign hit     = use_neg ? neg_hit : (IDX == tgt);

    always_comb begin
      ctl[i].op = CELL_HOLD;
      if (ins_go) begin
        if (hit) begin
          ctl[i].op = CELL_LOAD;
        end else if (ge) begin
          ctl[i].op = CELL_FROM_LEFT;
        end
      end else if (del_go && ge) begin
        ctl[i].op = CELL_FROM_RIGHT;
      end
    end

    if (i == 0) begin : g_head
      assign left = value_i;
    end else begin : g_body
      assign left = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_inner
      assign right = entry[i+1];
    end

    assign rem[i] = entry[i] & {DATA_W{del_go & hit}};

    plist_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl[i]),
      .left_i  (left),
      .right_i (right),
      .load_i  (value_i),
      .entry_o (entry[i])
    );
  end

  always_comb begin
    removed_d = '0;
    for (int i = 0; i < DEPTH; i++) begin
      removed_d = removed_d | rem[i];
    end
  end

  always_comb begin
    count_d = count_q;
    if (ins_go) begin
      count_d = count_q + CNT_W'(1);
    end else if (del_go) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_IGNORED;
    end else begin
      done_q <= acc;
      if (acc) begin
        count_q  <= count_d;
        status_q <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      removed_q <= removed_d;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign length_o        = LEN_W'(count_q);

endmodule

### src/plist_checker.sv
// Port-level checks for the positional ordered list, bound to the top level.
`timescale 1ns / 1ps
module plist_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic [plist_pkg::STAT_W-1:0] status_o,
  input logic [plist_pkg::DATA_W-1:0] removed_value_o,
  input logic [plist_pkg::LEN_W-1:0]  length_o
);
  import plist_pkg::*;

  a_done_follows_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("no result after command transfer");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without command transfer");

  a_length_kept_unless_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_DONE) |-> $stable(length_o))
    else $error("length changed on ignored command");

  a_no_removed_unless_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_DONE) |-> (removed_value_o == '0))
    else $error("removed value on ignored command");

endmodule

bind positional_ordered_list plist_checker u_plist_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .status_o        (status_o),
  .removed_value_o (removed_value_o),
  .length_o        (length_o)
);
